>>> hw/rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and constants for the I2C master bit sequencer
// Holds the beat formats, the classified operation codes and step limits.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int BYTE_BITS = 8;

    // Raw command kinds as they arrive on the input channel.
    localparam logic [2:0] KIND_START = 3'd0;
    localparam logic [2:0] KIND_STOP  = 3'd1;
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_TICK  = 3'd4;

    // Step counter limits of each sequence.
    localparam int WR_BIT_STEPS_I = 3 * BYTE_BITS;
    localparam int WR_LAST_I      = WR_BIT_STEPS_I + 3;
    localparam int RD_BIT_LAST_I  = 2 * BYTE_BITS;
    localparam int RD_LAST_I      = 2 * BYTE_BITS + 5;
    localparam int STEP_W         = $clog2(WR_LAST_I + 1);

    localparam logic [STEP_W-1:0] STEP_ZERO    = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_ONE     = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_TWO     = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_THREE   = STEP_W'(3);
    localparam logic [STEP_W-1:0] WR_BIT_STEPS = STEP_W'(WR_BIT_STEPS_I);
    localparam logic [STEP_W-1:0] WR_LAST      = STEP_W'(WR_LAST_I);
    localparam logic [STEP_W-1:0] RD_BIT_LAST  = STEP_W'(RD_BIT_LAST_I);
    localparam logic [STEP_W-1:0] RD_LAST      = STEP_W'(RD_LAST_I);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_START,
        MODE_STOP,
        MODE_WRITE,
        MODE_READ
    } mode_t;

    typedef enum logic [2:0] {
        OP_START,
        OP_STOP,
        OP_WRITE,
        OP_READ,
        OP_TICK,
        OP_NONE
    } op_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [BYTE_BITS-1:0] tx_byte;
        logic                 send_ack;
        logic                 sda_in;
    } in_item_t;

    typedef struct packed {
        logic                 scl_level;
        logic                 sda_level;
        logic                 sda_drive;
        logic                 busy_res;
        logic                 done_res;
        logic [BYTE_BITS-1:0] rx_byte;
        logic                 ack_seen;
        logic                 cmd_rejected;
    } out_item_t;

    // Classified entry carried from the front to the back through the queue.
    typedef struct packed {
        op_t                  op;
        logic [BYTE_BITS-1:0] tx_byte;
        logic                 send_ack;
        logic                 sda_in;
    } q_entry_t;

endpackage

>>> hw/rtl/i2c_master_bit_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top: I2C master pin sequencer
// A result beat is registered when the back end pops its input beat from the queue.
// Throughput: one beat per cycle while the result register is not stalled by res_ready.
// The two-entry queue absorbs output stalls while input beats keep coming.
// Reset (rst_n, asynchronous): idle, SCL and SDA high, SDA driven, queue empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  i2cms_pkg::in_item_t  cmd,
    output logic                 res_valid,
    input  logic                 res_ready,
    output i2cms_pkg::out_item_t res
);
    import i2cms_pkg::*;

    // The front end only decodes the kind of each beat; it has no storage,
    // so a beat is taken whenever the queue has a free slot.
    q_entry_t front_entry;
    q_entry_t q_data;
    logic     q_has_space;
    logic     q_has_data;
    logic     q_pop;

    assign cmd_ready = q_has_space;

    i2cms_front u_front (
        .cmd   (cmd),
        .entry (front_entry)
    );

    // The queue decouples acceptance from execution: the back end may be held
    // by a full result register while new beats are still taken in.
    i2cms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid && cmd_ready),
        .push_data (front_entry),
        .has_space (q_has_space),
        .pop       (q_pop),
        .has_data  (q_has_data),
        .pop_data  (q_data)
    );

    // The back end owns all sequencer state. Every queued beat, including a
    // rejected command or an idle tick, produces exactly one result beat.
    i2cms_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_has_data (q_has_data),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule

>>> hw/rtl/i2cms_front.sv
// ----------------------------------------------------------------------------
// i2cms_front: input classifier
// Decodes the raw kind of each beat into an operation code for the back end.
// ----------------------------------------------------------------------------
module i2cms_front (
    input  i2cms_pkg::in_item_t cmd,
    output i2cms_pkg::q_entry_t entry
);
    import i2cms_pkg::*;

    always_comb
    begin
        entry.tx_byte  = cmd.tx_byte;
        entry.send_ack = cmd.send_ack;
        entry.sda_in   = cmd.sda_in;
        case (cmd.kind)
            KIND_START: entry.op = OP_START;
            KIND_STOP:  entry.op = OP_STOP;
            KIND_WRITE: entry.op = OP_WRITE;
            KIND_READ:  entry.op = OP_READ;
            KIND_TICK:  entry.op = OP_TICK;
            // Unused kinds pass through as no-operations that still answer.
            default:    entry.op = OP_NONE;
        endcase
    end

endmodule

>>> hw/rtl/i2cms_queue.sv
// ----------------------------------------------------------------------------
// i2cms_queue: two-entry queue between front and back
// Lets the input side keep accepting while the back end is stalled.
// ----------------------------------------------------------------------------
module i2cms_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  i2cms_pkg::q_entry_t push_data,
    output logic                has_space,
    input  logic                pop,
    output logic                has_data,
    output i2cms_pkg::q_entry_t pop_data
);
    import i2cms_pkg::*;

    q_entry_t    slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign has_space = (count_reg != 2'd2);
    assign has_data  = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/i2cms_back.sv
// ----------------------------------------------------------------------------
// i2cms_back: pin sequencer and result register
// Carries out one queued operation a cycle while the result beat is not stalled, and holds the result beat.
// ----------------------------------------------------------------------------
module i2cms_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_has_data,
    input  i2cms_pkg::q_entry_t  q_data,
    output logic                 q_pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output i2cms_pkg::out_item_t res
);
    import i2cms_pkg::*;

    mode_t                mode_reg, mode_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [1:0]           phase_reg, phase_next;
    logic [BYTE_BITS-1:0] shift_reg, shift_next;
    logic [BYTE_BITS-1:0] rx_last_reg, rx_last_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 sda_oe_reg, sda_oe_next;
    logic                 ack_flag_reg, ack_flag_next;
    logic                 ack_to_send_reg, ack_to_send_next;
    logic                 res_valid_reg;
    out_item_t            res_reg;

    logic busy;
    logic is_cmd;
    logic load;
    logic tick_go;
    logic at_end;
    logic fin;

    assign q_pop   = q_has_data && (!res_valid_reg || res_ready);
    assign busy    = (mode_reg != MODE_IDLE);
    assign is_cmd  = (q_data.op inside {OP_START, OP_STOP, OP_WRITE, OP_READ});
    assign load    = q_pop && is_cmd && !busy;
    assign tick_go = q_pop && (q_data.op == OP_TICK) && busy;

    always_comb
    begin
        case (mode_reg)
            MODE_START, MODE_STOP: at_end = (step_reg == STEP_THREE);
            MODE_WRITE:            at_end = (step_reg == WR_LAST);
            MODE_READ:             at_end = (step_reg == RD_LAST);
            default:               at_end = 1'b0;
        endcase
        fin = tick_go && at_end;
    end

    // Next state: sequence mode, step counter and write bit phase.
    always_comb
    begin
        mode_next  = mode_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        if (load)
        begin
            step_next  = STEP_ZERO;
            phase_next = 2'd0;
            case (q_data.op)
                OP_START: mode_next = MODE_START;
                OP_STOP:  mode_next = MODE_STOP;
                OP_WRITE: mode_next = MODE_WRITE;
                default:  mode_next = MODE_READ;
            endcase
        end
        else if (tick_go)
        begin
            if (fin)
            begin
                mode_next = MODE_IDLE;
                step_next = STEP_ZERO;
            end
            else
            begin
                step_next = step_reg + STEP_ONE;
            end
            if ((mode_reg == MODE_WRITE) && (step_reg < WR_BIT_STEPS))
            begin
                phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
            end
        end
    end

    // Pin levels and data registers.
    always_comb
    begin
        shift_next       = shift_reg;
        rx_last_next     = rx_last_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        sda_oe_next      = sda_oe_reg;
        ack_flag_next    = ack_flag_reg;
        ack_to_send_next = ack_to_send_reg;
        if (load)
        begin
            if (q_data.op == OP_WRITE)
            begin
                shift_next = q_data.tx_byte;
            end
            else if (q_data.op == OP_READ)
            begin
                shift_next       = '0;
                ack_to_send_next = q_data.send_ack;
            end
        end
        else if (tick_go)
        begin
            case (mode_reg)
                MODE_START:
                begin
                    case (step_reg)
                        STEP_ZERO: scl_next = 1'b1;
                        STEP_ONE:  sda_next = 1'b1;
                        STEP_TWO:  sda_next = 1'b0;
                        default:   scl_next = 1'b0;
                    endcase
                end
                MODE_STOP:
                begin
                    case (step_reg)
                        STEP_ZERO: scl_next = 1'b0;
                        STEP_ONE:  sda_next = 1'b0;
                        STEP_TWO:  scl_next = 1'b1;
                        default:   sda_next = 1'b1;
                    endcase
                end
                MODE_WRITE:
                begin
                    if (step_reg < WR_BIT_STEPS)
                    begin
                        // The byte is shifted out from its top bit.
                        case (phase_reg)
                            2'd0:
                            begin
                                sda_next   = shift_reg[BYTE_BITS-1];
                                shift_next = {shift_reg[BYTE_BITS-2:0], 1'b0};
                            end
                            2'd1:    scl_next = 1'b1;
                            default: scl_next = 1'b0;
                        endcase
                    end
                    else if (step_reg == WR_BIT_STEPS)
                    begin
                        sda_oe_next = 1'b0;
                    end
                    else if (step_reg == WR_BIT_STEPS + STEP_ONE)
                    begin
                        scl_next      = 1'b1;
                        ack_flag_next = !q_data.sda_in;
                    end
                    else if (step_reg == WR_BIT_STEPS + STEP_TWO)
                    begin
                        scl_next = 1'b0;
                    end
                    else
                    begin
                        sda_oe_next = 1'b1;
                    end
                end
                MODE_READ:
                begin
                    if (step_reg == STEP_ZERO)
                    begin
                        sda_oe_next = 1'b0;
                    end
                    else if (step_reg <= RD_BIT_LAST)
                    begin
                        if (step_reg[0])
                        begin
                            scl_next   = 1'b1;
                            shift_next = {shift_reg[BYTE_BITS-2:0], q_data.sda_in};
                        end
                        else
                        begin
                            scl_next = 1'b0;
                        end
                    end
                    else if (step_reg == RD_BIT_LAST + STEP_ONE)
                    begin
                        sda_oe_next = 1'b1;
                    end
                    else if (step_reg == RD_BIT_LAST + STEP_TWO)
                    begin
                        sda_next = !ack_to_send_reg;
                    end
                    else if (step_reg == RD_BIT_LAST + STEP_THREE)
                    begin
                        scl_next = 1'b1;
                    end
                    else if (step_reg == RD_LAST - STEP_ONE)
                    begin
                        scl_next = 1'b0;
                    end
                    else
                    begin
                        sda_next     = 1'b1;
                        rx_last_next = shift_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            step_reg        <= STEP_ZERO;
            phase_reg       <= 2'd0;
            shift_reg       <= '0;
            rx_last_reg     <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            sda_oe_reg      <= 1'b1;
            ack_flag_reg    <= 1'b0;
            ack_to_send_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            step_reg        <= step_next;
            phase_reg       <= phase_next;
            shift_reg       <= shift_next;
            rx_last_reg     <= rx_last_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            sda_oe_reg      <= sda_oe_next;
            ack_flag_reg    <= ack_flag_next;
            ack_to_send_reg <= ack_to_send_next;
            if (q_pop)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg.scl_level    <= scl_next;
            res_reg.sda_level    <= sda_next;
            res_reg.sda_drive    <= sda_oe_next;
            res_reg.busy_res     <= (mode_next != MODE_IDLE);
            res_reg.done_res     <= fin;
            res_reg.rx_byte      <= rx_last_next;
            res_reg.ack_seen     <= ack_flag_next;
            res_reg.cmd_rejected <= is_cmd && busy;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> test/i2c_master_bit_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top_tb: self-checking bench for the I2C pin sequencer
// Drives command, tick and ignored-kind beats, with random gaps, through the valid/ready
// input channel. A beat-level model of the sequencer predicts one result beat
// per input beat. Result beats are taken with random stalls and compared,
// field by field, in order.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top_tb;

    import i2cms_pkg::*;

    // Number of tick beats that each command needs before it completes.
    localparam int START_TICKS = 4;
    localparam int STOP_TICKS  = 4;
    localparam int WRITE_TICKS = 3 * BYTE_BITS + 4;
    localparam int READ_TICKS  = 2 * BYTE_BITS + 6;

    localparam int TARGET_BEATS = 1700;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 40;

    // Kinds that the block treats as no-operations; each still gets a result beat.
    localparam logic [2:0] KIND_JUNK_LO = 3'd5;
    localparam logic [2:0] KIND_JUNK_HI = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    in_item_t  cmd = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    out_item_t res;

    // Stimulus waiting to be driven and results waiting to be seen.
    in_item_t  pending_beats[$];
    out_item_t expected_pins[$];

    int send_gap = 0;
    int recv_stall = 0;
    bit steady_send = 1'b0;
    bit steady_recv = 1'b0;
    int mismatch_count = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int useful_beats = 0;

    // Shadow copy of the sequencer state, updated once per accepted beat.
    mode_t      seq_mode = MODE_IDLE;
    logic [5:0] seq_step = '0;
    logic [7:0] seq_shift = '0;
    logic       pin_scl = 1'b1;
    logic       pin_sda = 1'b1;
    logic       pin_oe = 1'b1;
    logic       write_acked = 1'b0;
    logic       read_ack = 1'b0;
    logic [7:0] last_rx = '0;

    i2c_master_bit_sequencer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Makes the one pin change that the current step of the active sequence
    // calls for. Returns 1 when that change completes the sequence.
    function automatic logic advance_pins(logic sda_sample);
        logic fin;
        int   s;
        int   r;
        fin = 1'b0;
        s = int'(seq_step);
        case (seq_mode)
            MODE_START:
            begin
                if (s == 0) pin_scl = 1'b1;
                else if (s == 1) pin_sda = 1'b1;
                else if (s == 2) pin_sda = 1'b0;
                else
                begin
                    pin_scl = 1'b0;
                    fin = 1'b1;
                end
            end
            MODE_STOP:
            begin
                if (s == 0) pin_scl = 1'b0;
                else if (s == 1) pin_sda = 1'b0;
                else if (s == 2) pin_scl = 1'b1;
                else
                begin
                    pin_sda = 1'b1;
                    fin = 1'b1;
                end
            end
            MODE_WRITE:
            begin
                if (s < 3 * BYTE_BITS)
                begin
                    // Three steps per bit: present the data, raise SCL, drop SCL.
                    if (s % 3 == 0) pin_sda = seq_shift[BYTE_BITS - 1 - s / 3];
                    else if (s % 3 == 1) pin_scl = 1'b1;
                    else pin_scl = 1'b0;
                end
                else
                begin
                    r = s - 3 * BYTE_BITS;
                    if (r == 0) pin_oe = 1'b0;
                    else if (r == 1)
                    begin
                        // The slave acknowledges by holding SDA low while SCL is high after the byte.
                        pin_scl = 1'b1;
                        write_acked = (sda_sample == 1'b0);
                    end
                    else if (r == 2) pin_scl = 1'b0;
                    else
                    begin
                        pin_oe = 1'b1;
                        fin = 1'b1;
                    end
                end
            end
            MODE_READ:
            begin
                if (s == 0) pin_oe = 1'b0;
                else if (s <= 2 * BYTE_BITS)
                begin
                    // Odd steps raise SCL and shift in SDA, even steps drop SCL.
                    if (((s - 1) % 2) == 0)
                    begin
                        pin_scl = 1'b1;
                        seq_shift = {seq_shift[6:0], sda_sample};
                    end
                    else pin_scl = 1'b0;
                end
                else
                begin
                    r = s - (2 * BYTE_BITS + 1);
                    if (r == 0) pin_oe = 1'b1;
                    else if (r == 1) pin_sda = !read_ack;
                    else if (r == 2) pin_scl = 1'b1;
                    else if (r == 3) pin_scl = 1'b0;
                    else
                    begin
                        pin_sda = 1'b1;
                        last_rx = seq_shift;
                        fin = 1'b1;
                    end
                end
            end
            default: seq_mode = MODE_IDLE;
        endcase

        if (fin)
        begin
            seq_mode = MODE_IDLE;
            seq_step = '0;
        end
        else if (seq_mode != MODE_IDLE) seq_step = seq_step + 6'd1;
        return fin;
    endfunction

    // Applies one accepted input beat to the shadow state and returns the
    // result beat that the block must produce for it.
    function automatic out_item_t sequencer_step(in_item_t beat);
        out_item_t outcome;
        logic      busy_now;
        logic      finished;
        logic      refused;
        busy_now = (seq_mode != MODE_IDLE);
        finished = 1'b0;
        refused = 1'b0;
        if (beat.kind <= KIND_READ)
        begin
            // A command while a sequence runs is turned away with no effect.
            if (busy_now) refused = 1'b1;
            else
            begin
                seq_step = '0;
                case (beat.kind)
                    KIND_START: seq_mode = MODE_START;
                    KIND_STOP:  seq_mode = MODE_STOP;
                    KIND_WRITE:
                    begin
                        seq_mode = MODE_WRITE;
                        seq_shift = beat.tx_byte;
                    end
                    default:
                    begin
                        seq_mode = MODE_READ;
                        seq_shift = '0;
                        read_ack = beat.send_ack;
                    end
                endcase
            end
        end
        else if (beat.kind == KIND_TICK && busy_now) finished = advance_pins(beat.sda_in);

        outcome.scl_level = pin_scl;
        outcome.sda_level = pin_sda;
        outcome.sda_drive = pin_oe;
        outcome.busy_res = (seq_mode != MODE_IDLE);
        outcome.done_res = finished;
        outcome.rx_byte = last_rx;
        outcome.ack_seen = write_acked;
        outcome.cmd_rejected = refused;
        return outcome;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("result beat %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    endtask

    // Byte values lean towards the all-zero and all-one patterns.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Queues one beat as given; fields that its kind does not use keep the caller's values.
    task automatic queue_beat(logic [2:0] kind, logic [7:0] tx, logic ack, logic sda);
        in_item_t beat;
        beat.kind = kind;
        beat.tx_byte = tx;
        beat.send_ack = ack;
        beat.sda_in = sda;
        pending_beats.push_back(beat);
        if (kind <= KIND_TICK) useful_beats++;
    endtask

    task automatic queue_tick(logic sda);
        queue_beat(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
    endtask

    // One complete command with the ticks that carry it through. Now and then
    // a refused command or an ignored kind lands in the middle of it.
    task automatic queue_sequence(logic [2:0] kind);
        int ticks;
        case (kind)
            KIND_START: ticks = START_TICKS;
            KIND_STOP:  ticks = STOP_TICKS;
            KIND_WRITE: ticks = WRITE_TICKS;
            default:    ticks = READ_TICKS;
        endcase
        queue_beat(kind, pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                queue_beat(3'($urandom_range(0, 3)), pick_byte(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 29) == 0)
                queue_beat(3'($urandom_range(KIND_JUNK_LO, KIND_JUNK_HI)), pick_byte(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            queue_tick(1'($urandom_range(0, 1)));
        end
    endtask

    // Driver: the next pending beat goes out once the drawn gap has elapsed.
    // Valid is assigned once per edge, so back-to-back beats keep it high.
    always @(posedge clk)
    begin : drive_cmd
        logic keep_valid;
        keep_valid = cmd_valid;
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                expected_pins.push_back(sequencer_step(cmd));
                keep_valid = 1'b0;
                if ($urandom_range(0, 39) == 0) steady_send = !steady_send;
                send_gap = steady_send ? 0 : $urandom_range(0, 3);
            end
            if (!keep_valid)
            begin
                if (send_gap > 0) send_gap--;
                else if (pending_beats.size() > 0)
                begin
                    cmd <= pending_beats.pop_front();
                    keep_valid = 1'b1;
                end
            end
            cmd_valid <= keep_valid;
        end
    end

    // Monitor: every result beat is checked against the oldest prediction,
    // then ready is withheld for a drawn number of cycles.
    always @(posedge clk)
    begin : watch_res
        out_item_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_pins.size() == 0) report_mismatch("arrived with nothing expected");
                else
                begin
                    want = expected_pins.pop_front();
                    compare_field("scl_level", 8'(res.scl_level), 8'(want.scl_level));
                    compare_field("sda_level", 8'(res.sda_level), 8'(want.sda_level));
                    compare_field("sda_drive", 8'(res.sda_drive), 8'(want.sda_drive));
                    compare_field("busy_res", 8'(res.busy_res), 8'(want.busy_res));
                    compare_field("done_res", 8'(res.done_res), 8'(want.done_res));
                    compare_field("rx_byte", res.rx_byte, want.rx_byte);
                    compare_field("ack_seen", 8'(res.ack_seen), 8'(want.ack_seen));
                    compare_field("cmd_rejected", 8'(res.cmd_rejected), 8'(want.cmd_rejected));
                end
                results_seen++;
                if ($urandom_range(0, 39) == 0) steady_recv = !steady_recv;
                recv_stall = steady_recv ? 0 : $urandom_range(0, 3);
            end
            else if (recv_stall > 0) recv_stall--;
            res_ready <= (recv_stall == 0);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        // Directed opening: a tick and the ignored kinds while idle, then a
        // start with three refused commands and an ignored kind while it runs,
        // then a stop carried through to its end and a tick while idle.
        queue_tick(1'b0);
        queue_beat(3'd5, 8'h00, 1'b0, 1'b0);
        queue_beat(3'd6, 8'hFF, 1'b1, 1'b1);
        queue_beat(KIND_JUNK_HI, 8'hA5, 1'b1, 1'b0);
        queue_beat(KIND_START, 8'h00, 1'b0, 1'b0);
        queue_beat(KIND_WRITE, 8'hFF, 1'b1, 1'b1);
        queue_tick(1'b1);
        queue_beat(3'd6, 8'h5A, 1'b0, 1'b1);
        queue_beat(KIND_READ, 8'h00, 1'b1, 1'b0);
        queue_tick(1'b0);
        queue_beat(KIND_STOP, 8'hFF, 1'b0, 1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_beat(KIND_STOP, 8'h3C, 1'b1, 1'b0);
        for (int i = 0; i < STOP_TICKS; i++) queue_tick(1'($urandom_range(0, 1)));
        queue_tick(1'b1);

        // Random part: mostly whole transfers with random data and SDA
        // samples, the rest stray beats of any kind, which may start or
        // advance a sequence out of turn.
        while (useful_beats < TARGET_BEATS)
        begin
            if ($urandom_range(0, 99) < 85) queue_sequence(3'($urandom_range(0, 3)));
            else
                queue_beat(3'($urandom_range(0, 7)), pick_byte(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() > 0 || cmd_valid || expected_pins.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
